### src/tank_drive_mixer_core_macros.svh
// Assertion macros for the tank drive mixer checker.
// Included by the checker file only; no other dependencies.
`ifndef TANK_DRIVE_MIXER_CORE_MACROS_SVH
`define TANK_DRIVE_MIXER_CORE_MACROS_SVH

// Implication check, sampled on the rising clock, off during reset.
`define TDM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tank drive mixer: check failed");

// Invariant that must hold at every clock edge outside reset.
`define TDM_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tank drive mixer: invariant failed");

`endif

### src/tdm_pkg.sv
// Shared widths, register indexes, config struct and latencies for the tank drive mixer.
// No dependencies.
package tdm_pkg;

    localparam int IN_W       = 16;             // joystick and bound registers
    localparam int LIM_W      = 14;             // speed limit
    localparam int SPD_W      = 15;             // signed speed
    localparam int DUTY_W     = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int QUO_W  = LIM_W + 1;          // quotient holds up to 2 * limit
    localparam int PROD_W = IN_W + QUO_W;       // |v - low| * 2 * limit

    localparam int DUTY_FULL_DEF  = 4095;
    localparam int SPEED_FULL_DEF = 255;
    localparam int DUTY_CAP       = 4095;

    // Register stages per unit
    localparam int AXIS_LAT = QUO_W + 4;        // clamp, band, multiply, divide, map
    localparam int MIX_LAT  = 1;
    localparam int DUTY_LAT = 6;
    // Edges from the accepting edge to the edge that samples the strobe
    localparam int CORE_LAT = 1 + AXIS_LAT + MIX_LAT + DUTY_LAT;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INPUT_LOW   = 3'd0,
        REG_INPUT_HIGH  = 3'd1,
        REG_INPUT_MID   = 3'd2,
        REG_DEAD_BAND   = 3'd3,
        REG_SPEED_LIMIT = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic signed [IN_W-1:0] in_low;
        logic signed [IN_W-1:0] in_high;
        logic signed [IN_W-1:0] in_mid;
        logic [IN_W-1:0]        dead_band;
        logic [LIM_W-1:0]       speed_limit;
    } t_cfg;

endpackage

### src/tdm_axis.sv
// One joystick axis: clamp, dead band, scale and a bit-per-stage restoring divider.
// Depends on tdm_pkg.
module tdm_axis (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tdm_pkg::t_cfg                     i_cfg,
    input  logic                              i_valid,
    input  logic                              i_zero,
    input  logic signed [tdm_pkg::IN_W-1:0]   i_raw,
    output logic                              o_valid,
    output logic signed [tdm_pkg::SPD_W-1:0]  o_axis
);

    localparam int IN_W   = tdm_pkg::IN_W;
    localparam int LIM_W  = tdm_pkg::LIM_W;
    localparam int QUO_W  = tdm_pkg::QUO_W;
    localparam int PROD_W = tdm_pkg::PROD_W;
    localparam int SPD_W  = tdm_pkg::SPD_W;

    // Config-derived values; user must keep them static while items are in flight; unchecked
    logic signed [IN_W:0]   span;
    logic [IN_W-1:0]        span_abs;
    logic                   span_zero;
    logic [QUO_W-1:0]       two_lim;
    logic signed [IN_W+1:0] band_lo;
    logic signed [IN_W+1:0] band_hi;

    assign span      = (IN_W+1)'(i_cfg.in_high) - (IN_W+1)'(i_cfg.in_low);
    assign span_abs  = span[IN_W] ? IN_W'(-span) : span[IN_W-1:0];
    assign span_zero = (span == '0);
    assign two_lim   = {i_cfg.speed_limit, 1'b0};
    assign band_lo   = (IN_W+2)'(i_cfg.in_mid) - $signed({2'b00, i_cfg.dead_band});
    assign band_hi   = (IN_W+2)'(i_cfg.in_mid) + $signed({2'b00, i_cfg.dead_band});

    // Stage 1: clamp
    logic                   r1_vld;
    logic                   r1_zero;
    logic signed [IN_W-1:0] r1_v;
    logic signed [IN_W-1:0] n1_v;

    always_comb begin
        if (i_raw < i_cfg.in_low) begin
            n1_v = i_cfg.in_low;
        end else if (i_raw > i_cfg.in_high) begin
            n1_v = i_cfg.in_high;
        end else begin
            n1_v = i_raw;
        end
    end

    // Stage 2: dead band and offset from the low bound
    logic                 r2_vld;
    logic                 r2_zero;
    logic [IN_W-1:0]      r2_abs;
    logic signed [IN_W:0] diff;
    logic                 in_band;

    assign diff    = (IN_W+1)'(r1_v) - (IN_W+1)'(i_cfg.in_low);
    assign in_band = !(((IN_W+2)'(r1_v) < band_lo) || ((IN_W+2)'(r1_v) > band_hi));

    // Stage 3: scale by twice the limit
    logic              r3_vld;
    logic              r3_zero;
    logic [PROD_W-1:0] r3_prod;

    always_ff @(posedge i_clk) begin
        r1_v    <= n1_v;
        r1_zero <= i_zero;
        // reversed bounds only ever give v - low of zero or span, so the quotient stays >= 0
        r2_abs  <= diff[IN_W] ? IN_W'(-diff) : diff[IN_W-1:0];
        r2_zero <= r1_zero | in_band | span_zero;
        r3_prod <= PROD_W'(r2_abs) * PROD_W'(two_lim);
        r3_zero <= r2_zero;
    end

    // Divider: one quotient bit per stage; remainder stays below the divisor
    logic [IN_W-1:0]  r_dv_rem  [QUO_W];
    logic [QUO_W-1:0] r_dv_acc  [QUO_W];
    logic [QUO_W-1:0] r_dv_zero;
    logic [QUO_W-1:0] r_dv_vld;
    logic [IN_W-1:0]  n_dv_rem  [QUO_W];
    logic [QUO_W-1:0] n_dv_acc  [QUO_W];

    always_comb begin
        logic [IN_W-1:0]  rem_in;
        logic [QUO_W-1:0] acc_in;
        logic [IN_W:0]    trial;
        logic [IN_W:0]    reduced;
        logic             ge;
        for (int k = 0; k < QUO_W; k++) begin
            if (k == 0) begin
                rem_in = r3_prod[PROD_W-1:QUO_W];
                acc_in = r3_prod[QUO_W-1:0];
            end else begin
                rem_in = r_dv_rem[k-1];
                acc_in = r_dv_acc[k-1];
            end
            trial       = {rem_in, acc_in[QUO_W-1]};
            ge          = (trial >= {1'b0, span_abs});
            reduced     = trial - {1'b0, span_abs};
            n_dv_rem[k] = ge ? reduced[IN_W-1:0] : trial[IN_W-1:0];
            n_dv_acc[k] = {acc_in[QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QUO_W; k++) begin
            r_dv_rem[k] <= n_dv_rem[k];
            r_dv_acc[k] <= n_dv_acc[k];
        end
        r_dv_zero <= {r_dv_zero[QUO_W-2:0], r3_zero};
    end

    // Map stage: quotient minus limit
    logic                  r4_vld;
    logic signed [SPD_W:0] mapped;

    assign mapped = $signed({1'b0, r_dv_acc[QUO_W-1]}) -
                    $signed({{(SPD_W+1-LIM_W){1'b0}}, i_cfg.speed_limit});

    always_ff @(posedge i_clk) begin
        o_axis <= r_dv_zero[QUO_W-1] ? '0 : mapped[SPD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld   <= 1'b0;
            r2_vld   <= 1'b0;
            r3_vld   <= 1'b0;
            r_dv_vld <= '0;
            r4_vld   <= 1'b0;
        end else begin
            r1_vld   <= i_valid;
            r2_vld   <= r1_vld;
            r3_vld   <= r2_vld;
            r_dv_vld <= {r_dv_vld[QUO_W-2:0], r3_vld};
            r4_vld   <= r_dv_vld[QUO_W-1];
        end
    end

    assign o_valid = r4_vld;

endmodule

### src/tdm_duty.sv
// Direction line and 12-bit PWM duty from a signed speed, reciprocal-multiply division.
// Depends on tdm_pkg.
module tdm_duty #(
    parameter int DUTY_FULL  = tdm_pkg::DUTY_FULL_DEF,
    parameter int SPEED_FULL = tdm_pkg::SPEED_FULL_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic signed [tdm_pkg::SPD_W-1:0]  i_speed,
    output logic                              o_valid,
    output logic signed [tdm_pkg::SPD_W-1:0]  o_speed,
    output logic                              o_forward,
    output logic [tdm_pkg::DUTY_W-1:0]        o_duty
);

    localparam int LIM_W   = tdm_pkg::LIM_W;
    localparam int SPD_W   = tdm_pkg::SPD_W;
    localparam int DUTY_W  = tdm_pkg::DUTY_W;
    localparam int DF_W    = $clog2(DUTY_FULL + 1);
    localparam int N_W     = LIM_W + DF_W;
    localparam int P_W     = 2 * N_W + 1;
    localparam int STAGES  = tdm_pkg::DUTY_LAT;
    // floor(2^N_W / SPEED_FULL): estimate is low by at most one
    localparam logic [N_W:0] RECIP = (N_W+1)'((64'd1 << N_W) / SPEED_FULL);

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_POS,
        KIND_SUB,   // duty = full - q
        KIND_ADD    // duty = full + q
    } t_kind;

    // Speed and direction ride along to line up with the duty
    logic signed [SPD_W-1:0] r_spd [STAGES];
    t_kind                   r_kind [STAGES-1];
    logic [STAGES-1:0]       r_vld;

    // Stage 1: pick magnitude and case
    logic signed [SPD_W:0] shifted;
    logic [LIM_W-1:0]      n1_m;
    t_kind                 n1_kind;
    logic [LIM_W-1:0]      r1_m;

    assign shifted = (SPD_W+1)'(i_speed) + (SPD_W+1)'(SPEED_FULL);

    always_comb begin
        if (i_speed > 0) begin
            n1_kind = KIND_POS;
            n1_m    = i_speed[LIM_W-1:0];
        end else if (i_speed == 0) begin
            n1_kind = KIND_ZERO;
            n1_m    = '0;
        end else if (!shifted[SPD_W]) begin
            n1_kind = KIND_SUB;
            n1_m    = shifted[LIM_W-1:0];
        end else begin
            n1_kind = KIND_ADD;
            n1_m    = LIM_W'(-shifted);
        end
    end

    // Stages 2 to 5: N = m * full, q0 = N * recip >> N_W, q0 * speed_full, correct
    logic [N_W-1:0] r2_n;
    logic [N_W-1:0] r3_n;
    logic [N_W-1:0] r3_q0;
    logic [N_W-1:0] r4_n;
    logic [N_W-1:0] r4_q0;
    logic [N_W-1:0] r4_qd;
    logic [N_W-1:0] r5_q;
    logic [P_W-1:0] prod3;
    logic [N_W-1:0] resid;

    assign prod3 = P_W'(r2_n) * P_W'(RECIP);
    assign resid = r4_n - r4_qd;

    // Stage 6: combine with full scale and saturate
    logic signed [N_W+1:0] d_raw;

    always_comb begin
        case (r_kind[STAGES-2])
            KIND_POS: d_raw = $signed({2'b00, r5_q});
            KIND_SUB: d_raw = (N_W+2)'(DUTY_FULL) - $signed({2'b00, r5_q});
            KIND_ADD: d_raw = (N_W+2)'(DUTY_FULL) + $signed({2'b00, r5_q});
            default:  d_raw = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r1_m  <= n1_m;
        r2_n  <= N_W'(r1_m) * N_W'(DUTY_FULL);
        r3_n  <= r2_n;
        r3_q0 <= prod3[2*N_W-1:N_W];
        r4_n  <= r3_n;
        r4_q0 <= r3_q0;
        r4_qd <= N_W'(r3_q0) * N_W'(SPEED_FULL);
        r5_q  <= r4_q0 + N_W'(resid >= N_W'(SPEED_FULL));

        if (d_raw < 0) begin
            o_duty <= '0;
        end else if (d_raw > (N_W+2)'(tdm_pkg::DUTY_CAP)) begin
            o_duty <= DUTY_W'(tdm_pkg::DUTY_CAP);
        end else begin
            o_duty <= d_raw[DUTY_W-1:0];
        end

        r_spd[0]  <= i_speed;
        r_kind[0] <= n1_kind;
        for (int k = 1; k < STAGES; k++) begin
            r_spd[k] <= r_spd[k-1];
        end
        for (int k = 1; k < STAGES-1; k++) begin
            r_kind[k] <= r_kind[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    assign o_valid   = r_vld[STAGES-1];
    assign o_speed   = r_spd[STAGES-1];
    assign o_forward = (r_spd[STAGES-1] > 0);

endmodule

### src/tank_drive_mixer_core.sv
// Path to the result strobe: input register, axis pipelines, mixer register, duty pipelines.
// Throughput: one request per cycle; the 15-stage divider in each axis sets the depth.
// busy is low except in reset and the first cycle after it; results cannot be held off.
// Reset (i_rst_n low, synchronous) drops all requests in flight and restores register defaults.
// Top level of the tank drive mixer: config registers, input register, axis pipelines, mixer
// and duty pipelines. Depends on tdm_pkg, tdm_axis and tdm_duty.
module tank_drive_mixer_core #(
    parameter int DUTY_FULL  = tdm_pkg::DUTY_FULL_DEF,
    parameter int SPEED_FULL = tdm_pkg::SPEED_FULL_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_mode,
    input  logic signed [tdm_pkg::IN_W-1:0]      i_stick_x,
    input  logic signed [tdm_pkg::IN_W-1:0]      i_stick_y,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tdm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tdm_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                 o_strobe,
    output logic signed [tdm_pkg::SPD_W-1:0]     o_left_speed,
    output logic signed [tdm_pkg::SPD_W-1:0]     o_right_speed,
    output logic                                 o_left_forward,
    output logic [tdm_pkg::DUTY_W-1:0]           o_left_duty,
    output logic                                 o_right_forward,
    output logic [tdm_pkg::DUTY_W-1:0]           o_right_duty
);

    localparam int IN_W  = tdm_pkg::IN_W;
    localparam int LIM_W = tdm_pkg::LIM_W;
    localparam int SPD_W = tdm_pkg::SPD_W;

    logic          r_busy;
    tdm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.in_low      <= IN_W'(0);
            r_cfg.in_high     <= IN_W'(1023);
            r_cfg.in_mid      <= IN_W'(512);
            r_cfg.dead_band   <= IN_W'(20);
            r_cfg.speed_limit <= LIM_W'(255);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tdm_pkg::REG_INPUT_LOW:   r_cfg.in_low      <= $signed(i_cfg_data);
                tdm_pkg::REG_INPUT_HIGH:  r_cfg.in_high     <= $signed(i_cfg_data);
                tdm_pkg::REG_INPUT_MID:   r_cfg.in_mid      <= $signed(i_cfg_data);
                tdm_pkg::REG_DEAD_BAND:   r_cfg.dead_band   <= i_cfg_data;
                tdm_pkg::REG_SPEED_LIMIT: r_cfg.speed_limit <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    logic                   r_in_vld;
    logic                   r_in_mode;
    logic signed [IN_W-1:0] r_in_x;
    logic signed [IN_W-1:0] r_in_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_mode <= i_mode;
        r_in_x    <= i_stick_x;
        r_in_y    <= i_stick_y;
    end

    // Axes; a stop request forces both to zero, which mixes to zero speeds
    logic                    x_vld;
    logic                    y_vld;
    logic signed [SPD_W-1:0] x_axis;
    logic signed [SPD_W-1:0] y_axis;

    tdm_axis u_axis_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (r_in_vld),
        .i_zero  (r_in_mode),
        .i_raw   (r_in_x),
        .o_valid (x_vld),
        .o_axis  (x_axis)
    );

    tdm_axis u_axis_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (r_in_vld),
        .i_zero  (r_in_mode),
        .i_raw   (r_in_y),
        .o_valid (y_vld),
        .o_axis  (y_axis)
    );

    // Mixer
    logic signed [SPD_W:0]   lim;
    logic signed [SPD_W:0]   sum_l;
    logic signed [SPD_W:0]   sum_r;
    logic                    r_mix_vld;
    logic signed [SPD_W-1:0] r_mix_left;
    logic signed [SPD_W-1:0] r_mix_right;

    assign lim   = $signed({{(SPD_W+1-LIM_W){1'b0}}, r_cfg.speed_limit});
    assign sum_l = (SPD_W+1)'(y_axis) + (SPD_W+1)'(x_axis);
    assign sum_r = (SPD_W+1)'(y_axis) - (SPD_W+1)'(x_axis);

    always_ff @(posedge i_clk) begin
        if (sum_l > lim) begin
            r_mix_left <= lim[SPD_W-1:0];
        end else if (sum_l < -lim) begin
            r_mix_left <= SPD_W'(-lim);
        end else begin
            r_mix_left <= sum_l[SPD_W-1:0];
        end
        if (sum_r > lim) begin
            r_mix_right <= lim[SPD_W-1:0];
        end else if (sum_r < -lim) begin
            r_mix_right <= SPD_W'(-lim);
        end else begin
            r_mix_right <= sum_r[SPD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix_vld <= 1'b0;
        end else begin
            r_mix_vld <= x_vld && y_vld;
        end
    end

    // Duty pipelines; their final registers drive the result ports
    logic left_vld;
    logic right_vld;

    tdm_duty #(
        .DUTY_FULL  (DUTY_FULL),
        .SPEED_FULL (SPEED_FULL)
    ) u_duty_left (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_mix_vld),
        .i_speed   (r_mix_left),
        .o_valid   (left_vld),
        .o_speed   (o_left_speed),
        .o_forward (o_left_forward),
        .o_duty    (o_left_duty)
    );

    tdm_duty #(
        .DUTY_FULL  (DUTY_FULL),
        .SPEED_FULL (SPEED_FULL)
    ) u_duty_right (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_mix_vld),
        .i_speed   (r_mix_right),
        .o_valid   (right_vld),
        .o_speed   (o_right_speed),
        .o_forward (o_right_forward),
        .o_duty    (o_right_duty)
    );

    assign o_strobe = left_vld && right_vld;

endmodule

### src/tdm_checker.sv
// Port-level checks for tank_drive_mixer_core, attached by bind.
// Depends on tdm_pkg and tank_drive_mixer_core_macros.svh.
`include "tank_drive_mixer_core_macros.svh"

module tdm_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 i_mode,
    input logic                                 o_strobe,
    input logic signed [tdm_pkg::SPD_W-1:0]     o_left_speed,
    input logic signed [tdm_pkg::SPD_W-1:0]     o_right_speed,
    input logic                                 o_left_forward,
    input logic [tdm_pkg::DUTY_W-1:0]           o_left_duty,
    input logic                                 o_right_forward,
    input logic [tdm_pkg::DUTY_W-1:0]           o_right_duty
);

    localparam int LAT = tdm_pkg::CORE_LAT;

    logic req_taken;
    logic stop_taken;

    assign req_taken  = start && !busy && i_rst_n;
    assign stop_taken = req_taken && i_mode;

    // every result traces back to a request a fixed pipeline depth earlier
    `TDM_ASSERT_IMPL(a_result_has_request, i_clk, i_rst_n, o_strobe, $past(req_taken, LAT))

    `TDM_ASSERT_IMPL(a_direction_matches_sign, i_clk, i_rst_n, o_strobe,
        (o_left_forward == (o_left_speed > 0)) && (o_right_forward == (o_right_speed > 0)))

    // clamp keeps speeds symmetric, so the most negative code never shows
    `TDM_ASSERT_IMPL(a_speed_symmetric, i_clk, i_rst_n, o_strobe,
        (o_left_speed != 15'sh4000) && (o_right_speed != 15'sh4000))

    `TDM_ASSERT_IMPL(a_stop_gives_zero, i_clk, i_rst_n, o_strobe && $past(stop_taken, LAT),
        (o_left_speed == '0) && (o_right_speed == '0) && (o_left_duty == '0) &&
        (o_right_duty == '0) && !o_left_forward && !o_right_forward)

endmodule

bind tank_drive_mixer_core tdm_checker u_tdm_checker (.*);

### bench/testbench.sv
// Self-checking bench for tank_drive_mixer_core: joystick and stop requests from a job queue,
// register phases written between drains, results scored against an in-bench mixer model.
// Depends on tdm_pkg and the core RTL.
module testbench;
    import tdm_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = CORE_LAT + 10;
    localparam int QUIET_FIRST = 500;
    localparam int QUIET_LAST  = 800;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 150;
    localparam longint STICK_MIN = -32768;
    localparam longint STICK_MAX = 32767;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] IDX_TOP   = 3'd7;
    localparam logic MODE_DRIVE = 1'b0;
    localparam logic MODE_STOP  = 1'b1;

    typedef enum logic [1:0] {JOB_SAMPLE, JOB_REG, JOB_DRAIN} job_kind_e;

    typedef struct {
        job_kind_e              kind;
        logic                   mode;
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
    } job_t;

    typedef struct {
        logic signed [SPD_W-1:0] left_speed;
        logic signed [SPD_W-1:0] right_speed;
        logic                    left_fwd;
        logic [DUTY_W-1:0]       left_duty;
        logic                    right_fwd;
        logic [DUTY_W-1:0]       right_duty;
    } wheel_cmd_t;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         start       = 1'b0;
    logic                         busy;
    logic                         i_mode      = 1'b0;
    logic signed [IN_W-1:0]       i_stick_x   = '0;
    logic signed [IN_W-1:0]       i_stick_y   = '0;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data  = '0;
    logic                         o_strobe;
    logic signed [SPD_W-1:0]      o_left_speed;
    logic signed [SPD_W-1:0]      o_right_speed;
    logic                         o_left_forward;
    logic [DUTY_W-1:0]            o_left_duty;
    logic                         o_right_forward;
    logic [DUTY_W-1:0]            o_right_duty;

    job_t       job_q[$];
    wheel_cmd_t wheel_expect_q[$];
    int         n_sent = 0;
    int         n_recv = 0;
    int         mismatches = 0;
    int         stall_cycles = 0;

    // register copy seen by the predictor, updated when a write is taken
    longint mix_low = 0, mix_high = 1023, mix_mid = 512, mix_band = 20, mix_limit = 255;
    // register values as planned while the job queue is built
    longint plan_low = 0, plan_high = 1023, plan_mid = 512, plan_band = 20, plan_limit = 255;

    tank_drive_mixer_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_stick_x       (i_stick_x),
        .i_stick_y       (i_stick_y),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_left_speed    (o_left_speed),
        .o_right_speed   (o_right_speed),
        .o_left_forward  (o_left_forward),
        .o_left_duty     (o_left_duty),
        .o_right_forward (o_right_forward),
        .o_right_duty    (o_right_duty)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint axis_speed(longint raw);
        longint v;
        longint span;
        v = clip(raw, mix_low, mix_high);
        span = mix_high - mix_low;
        if (v >= mix_mid - mix_band && v <= mix_mid + mix_band) return 0;
        if (span == 0) return 0;
        return (v - mix_low) * (2 * mix_limit) / span - mix_limit;
    endfunction

    function automatic logic [DUTY_W-1:0] duty_for(longint s);
        longint d;
        if (s > 0)
            d = s * DUTY_FULL_DEF / SPEED_FULL_DEF;
        else if (s < 0)
            d = DUTY_FULL_DEF + (s + SPEED_FULL_DEF) * -DUTY_FULL_DEF / SPEED_FULL_DEF;
        else
            d = 0;
        return DUTY_W'(clip(d, 0, DUTY_CAP));
    endfunction

    function automatic wheel_cmd_t wheel_predict(logic mode, logic signed [IN_W-1:0] x,
                                                 logic signed [IN_W-1:0] y);
        longint xs;
        longint ys;
        longint l = 0;
        longint r = 0;
        wheel_cmd_t c;
        if (mode == MODE_DRIVE) begin
            xs = axis_speed(x);
            ys = axis_speed(y);
            l = clip(ys + xs, -mix_limit, mix_limit);
            r = clip(ys - xs, -mix_limit, mix_limit);
        end
        c.left_speed  = l[SPD_W-1:0];
        c.right_speed = r[SPD_W-1:0];
        c.left_fwd    = l > 0;
        c.left_duty   = duty_for(l);
        c.right_fwd   = r > 0;
        c.right_duty  = duty_for(r);
        return c;
    endfunction

    function automatic longint pick(longint a, longint b);
        return a + longint'($urandom_range(32'(b - a), 0));
    endfunction

    task automatic queue_sample(logic mode, longint x, longint y);
        job_t j;
        j = '{kind: JOB_SAMPLE, mode: mode, x: IN_W'(x), y: IN_W'(y), idx: '0, data: '0};
        job_q.push_back(j);
    endtask

    task automatic queue_reg(logic [CFG_IDX_W-1:0] idx, longint value);
        job_t j;
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'(value);
        j = '{kind: JOB_REG, mode: 1'b0, x: '0, y: '0, idx: idx, data: d};
        job_q.push_back(j);
        case (idx)
            REG_INPUT_LOW:   plan_low   = longint'($signed(d));
            REG_INPUT_HIGH:  plan_high  = longint'($signed(d));
            REG_INPUT_MID:   plan_mid   = longint'($signed(d));
            REG_DEAD_BAND:   plan_band  = longint'(d);
            REG_SPEED_LIMIT: plan_limit = longint'(d[LIM_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic queue_drain();
        job_t j;
        j = '{kind: JOB_DRAIN, mode: 1'b0, x: '0, y: '0, idx: '0, data: '0};
        job_q.push_back(j);
    endtask

    // stick value biased toward the planned input span and the dead-band edges
    function automatic longint stick_value();
        longint lo;
        longint hi;
        longint pt;
        int roll;
        lo = plan_low < plan_high ? plan_low : plan_high;
        hi = plan_low < plan_high ? plan_high : plan_low;
        roll = $urandom_range(99);
        if (roll < 15)
            pt = pick(STICK_MIN, STICK_MAX);
        else if (roll < 35)
            pt = plan_mid + ($urandom_range(1) ? plan_band : -plan_band) + pick(-2, 2);
        else if (roll < 42)
            pt = $urandom_range(1) ? lo : hi;
        else
            pt = pick(lo, hi);
        return clip(pt, STICK_MIN, STICK_MAX);
    endfunction

    task automatic queue_setting();
        longint lo;
        longint hi;
        longint mid;
        longint band;
        longint lim;
        case ($urandom_range(5))
            0: begin
                lo = pick(-2000, 500); hi = lo + pick(1, 4000); mid = pick(lo, hi);
                band = pick(0, 100); lim = pick(1, 2000);
            end
            1: begin
                lo = STICK_MIN; hi = STICK_MAX; mid = pick(-1000, 1000);
                band = pick(0, 3); lim = 16383;
            end
            2: begin
                hi = pick(-2000, 0); lo = hi + pick(1, 3000); mid = pick(hi, lo);
                band = pick(0, 50); lim = pick(1, 16383);
            end
            3: begin
                lo = pick(STICK_MIN, STICK_MAX); hi = lo; mid = lo;
                band = pick(0, 5); lim = pick(1, 500);
            end
            4: begin
                lo = pick(-500, 0); hi = lo + pick(1, 1500); mid = pick(lo, hi);
                band = pick(0, 20); lim = pick(0, 1);
            end
            default: begin
                lo = pick(STICK_MIN, STICK_MAX); hi = pick(STICK_MIN, STICK_MAX);
                mid = pick(STICK_MIN, STICK_MAX);
                band = $urandom_range(1) ? pick(0, 65535) : pick(0, 300);
                lim = pick(0, 16383);
            end
        endcase
        queue_reg(REG_INPUT_LOW, lo);
        queue_reg(REG_INPUT_HIGH, hi);
        queue_reg(REG_INPUT_MID, mid);
        queue_reg(REG_DEAD_BAND, band);
        // upper data bits are don't-care for the limit register
        queue_reg(REG_SPEED_LIMIT, lim | (longint'($urandom_range(3)) << LIM_W));
    endtask

    always @(posedge i_clk) begin : drive_proc
        job_t nxt;
        bit item_taken;
        bit reg_taken;
        bit drained;
        bit rest;
        bit go_sample;
        bit go_reg;
        bit retire;
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            item_taken = start && !busy;
            reg_taken  = i_cfg_valid && o_cfg_ready;
            if (item_taken) begin
                wheel_expect_q.push_back(wheel_predict(i_mode, i_stick_x, i_stick_y));
                n_sent <= n_sent + 1;
            end
            if (reg_taken) begin
                case (i_cfg_index)
                    REG_INPUT_LOW:   mix_low   = longint'($signed(i_cfg_data));
                    REG_INPUT_HIGH:  mix_high  = longint'($signed(i_cfg_data));
                    REG_INPUT_MID:   mix_mid   = longint'($signed(i_cfg_data));
                    REG_DEAD_BAND:   mix_band  = longint'(i_cfg_data);
                    REG_SPEED_LIMIT: mix_limit = longint'(i_cfg_data[LIM_W-1:0]);
                    default: ;
                endcase
            end
            // a request not yet taken stays on the ports unchanged
            if (!((start && !item_taken) || (i_cfg_valid && !reg_taken))) begin
                go_sample = 1'b0;
                go_reg    = 1'b0;
                retire    = 1'b0;
                drained   = (n_sent + item_taken) == n_recv;
                rest = !(n_sent >= QUIET_FIRST && n_sent < QUIET_LAST)
                       && $urandom_range(99) < 9;
                if (job_q.size() != 0) begin
                    nxt = job_q[0];
                    case (nxt.kind)
                        JOB_SAMPLE: if (!rest) begin
                            go_sample = 1'b1;
                            i_mode    <= nxt.mode;
                            i_stick_x <= nxt.x;
                            i_stick_y <= nxt.y;
                        end
                        JOB_REG: if (!rest && drained) begin
                            go_reg      = 1'b1;
                            i_cfg_index <= nxt.idx;
                            i_cfg_data  <= nxt.data;
                        end
                        default: retire = drained;
                    endcase
                    if (go_sample || go_reg || retire)
                        void'(job_q.pop_front());
                end
                start       <= go_sample;
                i_cfg_valid <= go_reg;
            end
        end
    end

    always @(posedge i_clk) begin : monitor_proc
        wheel_cmd_t want;
        bit bad;
        if (i_rst_n && o_strobe) begin
            n_recv <= n_recv + 1;
            if (wheel_expect_q.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("%0t: result with no request pending: L %0d R %0d",
                             $time, o_left_speed, o_right_speed);
            end else begin
                want = wheel_expect_q.pop_front();
                bad = want.left_speed  !== o_left_speed  || want.right_speed !== o_right_speed
                   || want.left_fwd    !== o_left_forward || want.left_duty  !== o_left_duty
                   || want.right_fwd   !== o_right_forward || want.right_duty !== o_right_duty;
                if (bad) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10) begin
                        $write("%0t: mismatch exp L %0d/%0b/%0d R %0d/%0b/%0d", $time,
                               want.left_speed, want.left_fwd, want.left_duty,
                               want.right_speed, want.right_fwd, want.right_duty);
                        $display("  got L %0d/%0b/%0d R %0d/%0b/%0d",
                                 o_left_speed, o_left_forward, o_left_duty,
                                 o_right_speed, o_right_forward, o_right_duty);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog_proc
        if (!i_rst_n || (start && !busy) || (i_cfg_valid && o_cfg_ready) || o_strobe)
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus_proc
        int ph;
        int k;
        // reset settings: span 0..1023, center 512, band 20, limit 255
        queue_sample(MODE_STOP, STICK_MAX, STICK_MIN);
        queue_sample(MODE_DRIVE, 512, 512);
        queue_sample(MODE_DRIVE, 492, 532);
        queue_sample(MODE_DRIVE, 491, 533);
        queue_sample(MODE_DRIVE, STICK_MIN, STICK_MIN);
        queue_sample(MODE_DRIVE, STICK_MAX, STICK_MAX);
        queue_sample(MODE_DRIVE, 512, 1023);
        queue_sample(MODE_DRIVE, 512, 0);
        queue_sample(MODE_DRIVE, 1023, 512);
        queue_sample(MODE_DRIVE, 0, 1023);
        queue_sample(MODE_DRIVE, 1023, 0);
        queue_sample(MODE_DRIVE, 700, 300);
        // unmapped indexes must leave every register alone
        queue_reg(IDX_SPARE, 16'hFFFF);
        queue_reg(IDX_TOP, 16'h8000);
        queue_sample(MODE_DRIVE, 300, 900);
        // equal bounds
        queue_reg(REG_INPUT_LOW, 100);
        queue_reg(REG_INPUT_HIGH, 100);
        queue_sample(MODE_DRIVE, -5, 300);
        // reversed bounds
        queue_reg(REG_INPUT_LOW, 1000);
        queue_reg(REG_INPUT_HIGH, -1000);
        queue_reg(REG_INPUT_MID, 0);
        queue_reg(REG_DEAD_BAND, 10);
        queue_sample(MODE_DRIVE, STICK_MIN, STICK_MAX);
        queue_sample(MODE_DRIVE, 0, 500);
        // zero limit
        queue_reg(REG_SPEED_LIMIT, 0);
        queue_sample(MODE_DRIVE, STICK_MAX, STICK_MIN);
        // widest span, no band, top limit (all-ones data checks the limit mask)
        queue_reg(REG_INPUT_LOW, STICK_MIN);
        queue_reg(REG_INPUT_HIGH, STICK_MAX);
        queue_reg(REG_DEAD_BAND, 0);
        queue_reg(REG_SPEED_LIMIT, 16'hFFFF);
        queue_sample(MODE_DRIVE, STICK_MIN, STICK_MAX);
        queue_sample(MODE_DRIVE, STICK_MAX, STICK_MIN);
        queue_sample(MODE_DRIVE, 1, -1);
        queue_sample(MODE_STOP, STICK_MIN, STICK_MIN);
        // widest band: everything falls in the dead zone
        queue_reg(REG_DEAD_BAND, 65535);
        queue_sample(MODE_DRIVE, STICK_MIN, STICK_MAX);

        for (ph = 0; ph < PHASES; ph++) begin
            queue_setting();
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == PHASES / 2 && k == PHASE_ITEMS / 2)
                    queue_drain();
                queue_sample($urandom_range(99) < 8 ? MODE_STOP : MODE_DRIVE,
                             stick_value(), stick_value());
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(negedge i_clk);
        while (job_q.size() != 0 || start || i_cfg_valid || n_sent != n_recv);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && wheel_expect_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
